// ===== design/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest polyline segment package
// Shared widths, defaults and the queue entry type.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int MaxVerticesDefault = 1024;
   localparam int CoordWidthDefault  = 16;
   localparam int InWidth            = 16;
   localparam int IdxWidth           = 10;
   localparam int DistWidth          = 17;
   localparam int MarginWidth        = 8;
   localparam logic [DistWidth-1:0] DistMax = '1;

   // one classified segment job, passed from front to back
   typedef struct packed {
      logic                 has_seg;   // a segment is closed by this vertex
      logic                 last;      // run ends with this vertex
      logic signed [17:0]   px;        // query minus start
      logic signed [17:0]   py;
      logic signed [17:0]   ex;        // query minus end
      logic signed [17:0]   ey;
      logic signed [17:0]   lx;        // end minus start
      logic signed [17:0]   ly;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_PICK, ST_SQRT, ST_DIV, ST_UPDATE, ST_OUT
   } back_state_type;

endpackage

// ===== design/nearest_polyline_segment_unit.sv =====
// ----------------------------------------------------------------------------
// Nearest polyline segment unit
//   channel | dir | fields
//   req_    | in  | query_x, query_y, vertex_x, vertex_y, last_vertex
//   rsp_    | out | segment_index, distance, found
//   csr_    | in  | tie_margin
// A closed segment holds the back end on the endpoint path for 4 product sums,
// a pick state, a 33-step square root and an update state; the perpendicular
// path adds a 51-step divide. A vertex without a segment skips these states.
// The result register loads in the output state after the last update, once
// any earlier result is taken. Synchronous reset clears run state; a two-entry
// queue lets the front accept while the back works.
// ----------------------------------------------------------------------------
module nearest_polyline_segment_unit #(
   parameter int MaxVertices = nps_pkg::MaxVerticesDefault,
   parameter int CoordWidth  = nps_pkg::CoordWidthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [nps_pkg::InWidth-1:0]   req_query_x,
   input  logic signed [nps_pkg::InWidth-1:0]   req_query_y,
   input  logic signed [nps_pkg::InWidth-1:0]   req_vertex_x,
   input  logic signed [nps_pkg::InWidth-1:0]   req_vertex_y,
   input  logic                                 req_last_vertex,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [nps_pkg::IdxWidth-1:0]         rsp_segment_index,
   output logic [nps_pkg::DistWidth-1:0]        rsp_distance,
   output logic                                 rsp_found,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nps_pkg::MarginWidth-1:0]      csr_tie_margin
);
   import nps_pkg::*;

   logic [MarginWidth-1:0] margin_ff;
   job_type f_job, q_job;
   logic f_valid, f_ready, q_valid, q_ready;

   assign csr_ready = 1'b1;

   // hold the margin register
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
      end else if (csr_valid) begin
         margin_ff <= csr_tie_margin;
      end
   end

   nps_front #(.MaxVertices(MaxVertices), .CoordWidth(CoordWidth)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_query_x, .req_query_y,
      .req_vertex_x, .req_vertex_y, .req_last_vertex,
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   nps_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
   );

   nps_back u_back (
      .clock, .reset, .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .tie_margin(margin_ff), .rsp_valid, .rsp_ready, .rsp_segment_index,
      .rsp_distance, .rsp_found
   );

endmodule

// ===== design/nps_front.sv =====
// ----------------------------------------------------------------------------
// Nearest polyline segment front end
// Accept vertices, form segment differences and push jobs to the queue.
// ----------------------------------------------------------------------------
module nps_front #(
   parameter int MaxVertices = nps_pkg::MaxVerticesDefault,
   parameter int CoordWidth  = nps_pkg::CoordWidthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [nps_pkg::InWidth-1:0]  req_query_x,
   input  logic signed [nps_pkg::InWidth-1:0]  req_query_y,
   input  logic signed [nps_pkg::InWidth-1:0]  req_vertex_x,
   input  logic signed [nps_pkg::InWidth-1:0]  req_vertex_y,
   input  logic                                req_last_vertex,
   output logic                                job_valid,
   input  logic                                job_ready,
   output nps_pkg::job_type                    job
);
   import nps_pkg::*;

   localparam int Eff = (CoordWidth > 16) ? 16 : CoordWidth;
   localparam int CntWidth = $clog2(MaxVertices);

   logic signed [15:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic have_prev_ff, have_prev_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic signed [17:0] qx, qy, vx, vy, ax, ay;
   logic take;

   // sign-extend from the effective coordinate width
   function automatic logic signed [17:0] sx(input logic [15:0] v);
      logic signed [15:0] t;
      t = $signed(v << (16 - Eff)) >>> (16 - Eff);
      return 18'(t);
   endfunction

   assign qx = sx(req_query_x);
   assign qy = sx(req_query_y);
   assign vx = sx(req_vertex_x);
   assign vy = sx(req_vertex_y);
   assign ax = 18'(prev_x_ff);
   assign ay = 18'(prev_y_ff);

   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign take = req_valid && job_ready;

   // classify the vertex
   always_comb begin
      job.has_seg = have_prev_ff && (32'(cnt_ff) < 32'(MaxVertices - 1));
      job.last    = req_last_vertex;
      job.px      = qx - ax;
      job.py      = qy - ay;
      job.ex      = qx - vx;
      job.ey      = qy - vy;
      job.lx      = vx - ax;
      job.ly      = vy - ay;
   end

   // advance run state
   always_comb begin
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      cnt_in       = cnt_ff;
      if (take) begin
         prev_x_in    = vx[15:0];
         prev_y_in    = vy[15:0];
         have_prev_in = !req_last_vertex;
         if (req_last_vertex) begin
            cnt_in = '0;
         end else if (job.has_seg) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
         cnt_ff       <= cnt_in;
      end
   end

endmodule

// ===== design/nps_queue.sv =====
// ----------------------------------------------------------------------------
// Nearest polyline segment job queue
// Two-entry register queue between front and back ends.
// ----------------------------------------------------------------------------
module nps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  nps_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output nps_pkg::job_type out_job
);
   import nps_pkg::*;

   job_type mem_ff [2];
   logic wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_job;
      end
   end

   // move pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== design/nps_back.sv =====
// ----------------------------------------------------------------------------
// Nearest polyline segment back end
// Distance by iterative square root and division, then best-segment update.
// ----------------------------------------------------------------------------
module nps_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  job_valid,
   output logic                                  job_ready,
   input  nps_pkg::job_type                      job,
   input  logic [nps_pkg::MarginWidth-1:0]       tie_margin,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [nps_pkg::IdxWidth-1:0]          rsp_segment_index,
   output logic [nps_pkg::DistWidth-1:0]         rsp_distance,
   output logic                                  rsp_found
);
   import nps_pkg::*;

   back_state_type st_ff, st_in;
   job_type j_ff, j_in;
   // products, 38 bits signed
   logic signed [37:0] dot_ff, dot_in, lp_ff, lp_in, cr_ff, cr_in;
   logic signed [37:0] pp_ff, pp_in;
   logic [1:0] ph_ff, ph_in;
   // sqrt unit: radicand up to 66 bits, root up to 33
   logic [65:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] root_ff, root_in;
   logic [5:0] it_ff, it_in;
   logic is_seg_ff, is_seg_in;
   // divider
   logic [50:0] num_ff, num_in;
   logic [33:0] drem_ff, drem_in;
   logic [17:0] quo_ff, quo_in;
   logic [DistWidth-1:0] d_ff, d_in;
   logic [DistWidth-1:0] best_ff, best_in;
   logic [IdxWidth-1:0] bidx_ff, bidx_in, seg_ff, seg_in;
   logic any_ff, any_in;
   logic [IdxWidth-1:0] oidx_ff, oidx_in;
   logic [DistWidth-1:0] odist_ff, odist_in;
   logic ofound_ff, ofound_in;
   logic ovalid_ff, ovalid_in;
   logic signed [17:0] ma, mb, mc, md;
   logic signed [37:0] msum;
   logic [33:0] trial;
   logic [34:0] sh;
   logic [34:0] dsh;

   // a waiting result only holds the output state, not the next job
   assign job_ready = (st_ff == ST_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_segment_index = oidx_ff;
   assign rsp_distance = odist_ff;
   assign rsp_found = ofound_ff;

   // shared pair of multipliers, one product sum per cycle
   always_comb begin
      ma = j_ff.lx; mb = j_ff.lx; mc = j_ff.ly; md = j_ff.ly;
      case (ph_ff)
         2'd0: begin ma = j_ff.lx; mb = j_ff.lx; mc = j_ff.ly; md = j_ff.ly; end
         2'd1: begin ma = j_ff.lx; mb = j_ff.px; mc = j_ff.ly; md = j_ff.py; end
         2'd2: begin ma = j_ff.px; mb = j_ff.ly; mc = -j_ff.py; md = j_ff.lx; end
         default: begin ma = j_ff.px; mb = j_ff.px; mc = j_ff.py; md = j_ff.py; end
      endcase
      msum = 38'(ma * mb) + 38'(mc * md);
   end

   always_comb begin
      sh    = {rem_ff[32:0], rad_ff[65:64]};
      trial = {root_ff[31:0], 2'b01};
      dsh   = {drem_ff, num_ff[50]};
   end

   always_comb begin
      st_in = st_ff; j_in = j_ff;
      dot_in = dot_ff; lp_in = lp_ff; cr_in = cr_ff; pp_in = pp_ff;
      ph_in = ph_ff; rad_in = rad_ff; rem_in = rem_ff; root_in = root_ff;
      it_in = it_ff; is_seg_in = is_seg_ff;
      num_in = num_ff; drem_in = drem_ff; quo_in = quo_ff; d_in = d_ff;
      best_in = best_ff; bidx_in = bidx_ff; seg_in = seg_ff; any_in = any_ff;
      oidx_in = oidx_ff; odist_in = odist_ff; ofound_in = ofound_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      case (st_ff)
         ST_IDLE: begin
            if (job_valid && job_ready) begin
               j_in = job;
               ph_in = 2'd0;
               st_in = job.has_seg ? ST_MUL : (job.last ? ST_OUT : ST_IDLE);
            end
         end
         ST_MUL: begin
            // four product sums, one a cycle
            case (ph_ff)
               2'd0: dot_in = msum;
               2'd1: lp_in = msum;
               2'd2: cr_in = msum;
               default: pp_in = msum;
            endcase
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd3) begin
               st_in = ST_PICK;
            end
         end
         ST_PICK: begin
            // choose endpoint or perpendicular path
            rem_in = '0; root_in = '0; it_in = '0;
            st_in = ST_SQRT;
            if (dot_ff == 0 || lp_ff < 0) begin
               rad_in = {30'd0, 36'(pp_ff)}; is_seg_in = 1'b0;
            end else if (lp_ff > dot_ff) begin
               rad_in = {30'd0, 36'(38'(j_ff.ex * j_ff.ex) + 38'(j_ff.ey * j_ff.ey))};
               is_seg_in = 1'b0;
            end else begin
               rad_in = {2'b0, 36'(dot_ff), 28'd0}; is_seg_in = 1'b1;
            end
         end
         ST_SQRT: begin
            // one root bit a cycle
            if (34'(sh) >= trial) begin
               rem_in  = 34'(sh) - trial;
               root_in = {root_ff[31:0], 1'b1};
            end else begin
               rem_in  = 34'(sh);
               root_in = {root_ff[31:0], 1'b0};
            end
            rad_in = {rad_ff[63:0], 2'b00};
            it_in = it_ff + 6'd1;
            if (it_ff == 6'd32) begin
               if (!is_seg_ff) begin
                  d_in = (root_in > 33'(DistMax)) ? DistMax : root_in[DistWidth-1:0];
                  st_in = ST_UPDATE;
               end else begin
                  num_in = {(cr_ff < 0) ? 37'(-cr_ff) : 37'(cr_ff), 14'd0};
                  drem_in = '0; quo_in = '0; it_in = '0;
                  st_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // restoring division, one bit a cycle, quotient capped at 18 bits
            if (dsh >= {2'b0, root_ff}) begin
               drem_in = 34'(dsh - {2'b0, root_ff});
               quo_in = {quo_ff[16:0], 1'b1} | {17'd0, quo_ff[17]};
            end else begin
               drem_in = dsh[33:0];
               quo_in = {quo_ff[16:0], 1'b0} | {17'd0, quo_ff[17]};
            end
            if (quo_ff[17]) quo_in = 18'h3FFFF;
            num_in = {num_ff[49:0], 1'b0};
            it_in = it_ff + 6'd1;
            if (it_ff == 6'd50) begin
               d_in = quo_in[17] ? DistMax : quo_in[DistWidth-1:0];
               st_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!any_ff || (18'(d_ff) + 18'(tie_margin) < 18'(best_ff))) begin
               best_in = d_ff; bidx_in = seg_ff;
            end
            any_in = 1'b1;
            seg_in = seg_ff + 1'b1;
            st_in = j_ff.last ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (!ovalid_ff) begin
               ovalid_in = 1'b1;
               oidx_in = any_ff ? bidx_ff : '0;
               odist_in = any_ff ? best_ff : DistMax;
               ofound_in = any_ff;
               best_in = DistMax; bidx_in = '0; seg_in = '0; any_in = 1'b0;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in; dot_ff <= dot_in; lp_ff <= lp_in; cr_ff <= cr_in;
      pp_ff <= pp_in; rad_ff <= rad_in; rem_ff <= rem_in;
      root_ff <= root_in; it_ff <= it_in; is_seg_ff <= is_seg_in; ph_ff <= ph_in;
      num_ff <= num_in; drem_ff <= drem_in; quo_ff <= quo_in; d_ff <= d_in;
      oidx_ff <= oidx_in; odist_ff <= odist_in; ofound_ff <= ofound_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ovalid_ff <= 1'b0;
         best_ff <= DistMax; bidx_ff <= '0; seg_ff <= '0; any_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ovalid_ff <= ovalid_in;
         best_ff <= best_in; bidx_ff <= bidx_in; seg_ff <= seg_in; any_ff <= any_in;
      end
   end

endmodule
